// ===== design/wg_pkg.sv =====
// shared types and constants of the waveform generator
package wg_pkg;

  localparam int unsigned TIME_W  = 48;
  localparam int unsigned INDEX_W = 32;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [16:0] DUTY_RESET = 17'd6554;

  typedef enum logic [2:0] {
    MODE_CONST   = 3'd0,
    MODE_SINE    = 3'd1,
    MODE_TRI     = 3'd2,
    MODE_SQUARE  = 3'd3,
    MODE_RAMP    = 3'd4,
    MODE_COUNTER = 3'd5,
    MODE_PULSE   = 3'd6
  } wave_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE       = 3'd0,
    REG_FREQ       = 3'd1,
    REG_AMPLITUDE  = 3'd2,
    REG_OFFSET     = 3'd3,
    REG_PHASE      = 3'd4,
    REG_DUTY       = 3'd5,
    REG_PULSE_LOW  = 3'd6,
    REG_PULSE_HIGH = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0]         wave_mode;
    logic [31:0]        frequency_hz;
    logic signed [31:0] amplitude_level;
    logic signed [31:0] offset_level;
    logic [15:0]        phase_fraction;
    logic [16:0]        pulse_duty;
    logic signed [31:0] pulse_low_level;
    logic signed [31:0] pulse_high_level;
  } cfg_t;

endpackage

// ===== design/wg_mod.sv =====
// pipelined remainder of elapsed time by the frequency register, one bit per stage
module wg_mod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [wg_pkg::TIME_W-1:0]   time_i,
  input  logic [wg_pkg::INDEX_W-1:0]  index_i,
  input  logic [31:0]                 divisor_i,
  output logic                        valid_o,
  output logic [wg_pkg::TIME_W-1:0]   time_o,
  output logic [wg_pkg::INDEX_W-1:0]  index_o,
  output logic [31:0]                 rem_o
);
  import wg_pkg::*;

  logic [31:0]         rem_q   [TIME_W];
  logic [TIME_W-1:0]   time_q  [TIME_W];
  logic [INDEX_W-1:0]  index_q [TIME_W];
  logic [TIME_W-1:0]   valid_q;

  for (genvar j = 0; j < TIME_W; j++) begin : g_stage
    logic [31:0]        rem_in;
    logic [TIME_W-1:0]  time_in;
    logic [INDEX_W-1:0] index_in;
    logic               valid_in;
    logic [32:0]        trial;
    logic [31:0]        rem_d;

    if (j == 0) begin : g_first
      assign rem_in   = '0;
      assign time_in  = time_i;
      assign index_in = index_i;
      assign valid_in = valid_i;
    end else begin : g_next
      assign rem_in   = rem_q[j-1];
      assign time_in  = time_q[j-1];
      assign index_in = index_q[j-1];
      assign valid_in = valid_q[j-1];
    end

    always_comb begin
      trial = {rem_in, time_in[TIME_W-1-j]};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = 32'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[31:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j] <= 1'b0;
      end else if (en_i) begin
        valid_q[j] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]   <= rem_d;
        time_q[j]  <= time_in;
        index_q[j] <= index_in;
      end
    end
  end

  assign valid_o = valid_q[TIME_W-1];
  assign time_o  = time_q[TIME_W-1];
  assign index_o = index_q[TIME_W-1];
  assign rem_o   = (divisor_i != '0) ? rem_q[TIME_W-1] : '0;

  // a finished remainder is always below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && divisor_i != '0) |-> (rem_o < divisor_i))
    else $error("remainder not below divisor");

endmodule

// ===== design/wg_phase.sv =====
// cycle phase: fractional part of time times frequency, plus phase offset
module wg_phase #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [wg_pkg::TIME_W-1:0]   time_i,
  input  logic [wg_pkg::INDEX_W-1:0]  index_i,
  input  logic [31:0]                 rem_i,
  input  wg_pkg::cfg_t                cfg_i,
  output logic                        valid_o,
  output logic [31:0]                 phase_o,
  output logic [wg_pkg::INDEX_W-1:0]  index_o,
  output logic [31:0]                 rem_o
);
  import wg_pkg::*;

  logic [63:0]        lo_prod_q;
  logic [47:0]        hi_prod_q;
  logic [INDEX_W-1:0] index1_q, index2_q;
  logic [31:0]        rem1_q, rem2_q;
  logic               valid1_q, valid2_q;
  logic [63:0]        prod_sum;
  logic [31:0]        frac_p;
  logic [31:0]        phase_d, phase_q;

  assign prod_sum = lo_prod_q + {hi_prod_q[31:0], 32'd0};

  if (2 * FRACTION_BITS >= 32) begin : g_wide
    assign frac_p = prod_sum[2*FRACTION_BITS-1 -: 32];
  end else begin : g_narrow
    assign frac_p = {prod_sum[2*FRACTION_BITS-1:0], (32 - 2*FRACTION_BITS)'(0)};
  end

  assign phase_d = frac_p + {cfg_i.phase_fraction, 16'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_prod_q <= time_i[31:0] * cfg_i.frequency_hz;
      hi_prod_q <= time_i[TIME_W-1:32] * cfg_i.frequency_hz;
      index1_q  <= index_i;
      rem1_q    <= rem_i;
      phase_q   <= phase_d;
      index2_q  <= index1_q;
      rem2_q    <= rem1_q;
    end
  end

  assign valid_o = valid2_q;
  assign phase_o = phase_q;
  assign index_o = index2_q;
  assign rem_o   = rem2_q;

endmodule

// ===== design/wg_shape.sv =====
// waveform shaping: sine rom, shape select, gain, offset and saturation
module wg_shape #(
  parameter int unsigned SINE_TABLE_BITS = 10,
  parameter int unsigned FRACTION_BITS   = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [31:0]                 phase_i,
  input  logic [wg_pkg::INDEX_W-1:0]  index_i,
  input  logic [31:0]                 rem_i,
  input  wg_pkg::cfg_t                cfg_i,
  output logic                        valid_o,
  output logic signed [31:0]          value_o,
  output logic                        sat_o
);
  import wg_pkg::*;

  localparam int unsigned N = 1 << SINE_TABLE_BITS;
  localparam int unsigned F = FRACTION_BITS;
  localparam logic signed [33:0] ONE_W = 34'sd1 <<< F;

  typedef logic [F:0] sine_tab_t [N+1];

  // evaluated once at elaboration, the divisors are fixed per series term
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] x, x2, term, v;
    longint      sum;
    for (int k = 0; k <= N; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n[0]) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (64'(sum) + (64'd1 << (29 - F))) >> (30 - F);
      if (v > (64'd1 << F)) begin
        v = 64'd1 << F;
      end
      tab[k] = v[F:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // stage a: rom read and non-sine shapes
  logic [SINE_TABLE_BITS-1:0] tab_idx;
  logic [SINE_TABLE_BITS:0]   tab_addr;
  logic [31:0]                tri_dist;
  logic signed [33:0]         tri_w, other_w_d;
  logic                       pulse_hi_d;

  logic [F:0]         rom_q;
  logic signed [33:0] other_w_q;
  logic               neg_q, pulse_hi_a_q;
  logic [INDEX_W-1:0] index_a_q;
  logic               valid_a_q;

  assign tab_idx  = phase_i[29 -: SINE_TABLE_BITS];
  assign tab_addr = phase_i[30] ? ((SINE_TABLE_BITS+1)'(N) - {1'b0, tab_idx})
                                : {1'b0, tab_idx};
  assign tri_dist = phase_i[31] ? (phase_i - 32'h8000_0000) : (32'h8000_0000 - phase_i);
  assign tri_w    = $signed(34'(tri_dist >> (30 - F))) - ONE_W;
  assign pulse_hi_d = {1'b0, phase_i} <= {cfg_i.pulse_duty, 16'd0};

  always_comb begin
    unique case (cfg_i.wave_mode)
      MODE_CONST:  other_w_d = ONE_W;
      MODE_TRI:    other_w_d = tri_w;
      MODE_SQUARE: other_w_d = phase_i[31] ? ONE_W : -ONE_W;
      MODE_RAMP:   other_w_d = $signed({2'b00, rem_i});
      default:     other_w_d = '0;
    endcase
  end

  // stage b: signed sine, operand select
  logic signed [33:0] w_d, w_q, operand_q;
  logic               pulse_hi_b_q, valid_b_q;

  assign w_d = (cfg_i.wave_mode == MODE_SINE)
             ? (neg_q ? -$signed(34'(rom_q)) : $signed(34'(rom_q)))
             : other_w_q;

  // stage c: one gain multiply
  logic signed [65:0] prod_q;
  logic               pulse_hi_c_q, valid_c_q;

  // stage d: offset and saturation
  logic signed [66:0] scaled, level_sum;
  logic signed [31:0] value_q;
  logic               sat_d, sat_q, valid_d_q;

  always_comb begin
    unique case (cfg_i.wave_mode)
      MODE_COUNTER: scaled = 67'(prod_q);
      MODE_PULSE:   scaled = pulse_hi_c_q ? 67'(cfg_i.pulse_high_level)
                                          : 67'(cfg_i.pulse_low_level);
      default:      scaled = 67'(prod_q >>> F);
    endcase
    level_sum = 67'(cfg_i.offset_level) + scaled;
    sat_d     = (level_sum > 67'sd2147483647) || (level_sum < -67'sd2147483648);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
      valid_d_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
      valid_d_q <= valid_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rom_q        <= SINE_TAB[tab_addr];
      other_w_q    <= other_w_d;
      neg_q        <= phase_i[31];
      pulse_hi_a_q <= pulse_hi_d;
      index_a_q    <= index_i;

      w_q          <= w_d;
      operand_q    <= (cfg_i.wave_mode == MODE_COUNTER) ? $signed({2'b00, index_a_q}) : w_d;
      pulse_hi_b_q <= pulse_hi_a_q;

      prod_q       <= 66'(cfg_i.amplitude_level) * 66'(operand_q);
      pulse_hi_c_q <= pulse_hi_b_q;

      sat_q        <= sat_d;
      if (level_sum > 67'sd2147483647) begin
        value_q <= 32'sh7FFF_FFFF;
      end else if (level_sum < -67'sd2147483648) begin
        value_q <= 32'sh8000_0000;
      end else begin
        value_q <= level_sum[31:0];
      end
    end
  end

  assign valid_o = valid_d_q;
  assign value_o = value_q;
  assign sat_o   = sat_q;

  // the sine magnitude never exceeds one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_b_q && cfg_i.wave_mode == MODE_SINE) |-> ((w_q <= ONE_W) && (w_q >= -ONE_W)))
    else $error("sine value out of range");

endmodule

// ===== design/waveform_generator.sv =====
// waveform generator top level: configuration registers and pipeline
// One sample per clock unless stalled: a tick transfer passes 48 stages for the ramp
// remainder, two for the phase multiply, four for shaping, gain and saturation. The
// whole pipeline advances together and holds while out_stall_i holds a finished sample.
// The user must write configuration only while the pipeline is empty; not enforced.
module waveform_generator #(
  parameter int unsigned SINE_TABLE_BITS = 10,
  parameter int unsigned FRACTION_BITS   = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [wg_pkg::INDEX_W-1:0]         sample_index_i,
  input  logic [wg_pkg::TIME_W-1:0]          elapsed_time_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [wg_pkg::VALUE_W-1:0]  sample_value_o,
  output logic                               saturated_o,
  input  logic                               cfg_we_i,
  input  logic [wg_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [31:0]                        cfg_data_i
);
  import wg_pkg::*;

  localparam logic [31:0] ONE_Q = 32'd1 << FRACTION_BITS;

  cfg_t cfg_q;
  logic en;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wave_mode        <= MODE_SINE;
      cfg_q.frequency_hz     <= ONE_Q;
      cfg_q.amplitude_level  <= $signed(ONE_Q);
      cfg_q.offset_level     <= '0;
      cfg_q.phase_fraction   <= '0;
      cfg_q.pulse_duty       <= DUTY_RESET;
      cfg_q.pulse_low_level  <= '0;
      cfg_q.pulse_high_level <= $signed(ONE_Q);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MODE:       cfg_q.wave_mode        <= cfg_data_i[2:0];
        REG_FREQ:       cfg_q.frequency_hz     <= cfg_data_i;
        REG_AMPLITUDE:  cfg_q.amplitude_level  <= $signed(cfg_data_i);
        REG_OFFSET:     cfg_q.offset_level     <= $signed(cfg_data_i);
        REG_PHASE:      cfg_q.phase_fraction   <= cfg_data_i[15:0];
        REG_DUTY:       cfg_q.pulse_duty       <= cfg_data_i[16:0];
        REG_PULSE_LOW:  cfg_q.pulse_low_level  <= $signed(cfg_data_i);
        REG_PULSE_HIGH: cfg_q.pulse_high_level <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  logic               mod_valid, ph_valid;
  logic [TIME_W-1:0]  mod_time;
  logic [INDEX_W-1:0] mod_index, ph_index;
  logic [31:0]        mod_rem, ph_rem, ph_phase;

  wg_mod u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .time_i    (elapsed_time_i),
    .index_i   (sample_index_i),
    .divisor_i (cfg_q.frequency_hz),
    .valid_o   (mod_valid),
    .time_o    (mod_time),
    .index_o   (mod_index),
    .rem_o     (mod_rem)
  );

  wg_phase #(.FRACTION_BITS(FRACTION_BITS)) u_phase (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mod_valid),
    .time_i  (mod_time),
    .index_i (mod_index),
    .rem_i   (mod_rem),
    .cfg_i   (cfg_q),
    .valid_o (ph_valid),
    .phase_o (ph_phase),
    .index_o (ph_index),
    .rem_o   (ph_rem)
  );

  wg_shape #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS),
    .FRACTION_BITS   (FRACTION_BITS)
  ) u_shape (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ph_valid),
    .phase_i (ph_phase),
    .index_i (ph_index),
    .rem_i   (ph_rem),
    .cfg_i   (cfg_q),
    .valid_o (out_valid_o),
    .value_o (sample_value_o),
    .sat_o   (saturated_o)
  );

  // a clipped sample sits at one end of the range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (sample_value_o == 32'sh7FFF_FFFF || sample_value_o == 32'sh8000_0000))
    else $error("saturated sample not at range limit");

  // unit square wave gives plus or minus one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && cfg_q.wave_mode == MODE_SQUARE && cfg_q.amplitude_level == $signed(ONE_Q)
     && cfg_q.offset_level == '0) |->
      (sample_value_o == $signed(ONE_Q) || sample_value_o == -$signed(ONE_Q)))
    else $error("square wave level wrong");

endmodule
